### design/des_pkg.sv
`timescale 1ns / 1ps
// DES tables, constants and permutation functions shared by the encryptor.
package des_pkg;

   localparam int ROUNDS        = 16;
   localparam int HALF_KEY_BITS = 28;

   typedef logic [7:0] tab_entry_type;

   localparam tab_entry_type IP_TAB [64] = '{
      8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
      8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
      8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
      8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
      8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
      8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
      8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
      8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7};

   localparam tab_entry_type FP_TAB [64] = '{
      8'd40, 8'd8, 8'd48, 8'd16, 8'd56, 8'd24, 8'd64, 8'd32,
      8'd39, 8'd7, 8'd47, 8'd15, 8'd55, 8'd23, 8'd63, 8'd31,
      8'd38, 8'd6, 8'd46, 8'd14, 8'd54, 8'd22, 8'd62, 8'd30,
      8'd37, 8'd5, 8'd45, 8'd13, 8'd53, 8'd21, 8'd61, 8'd29,
      8'd36, 8'd4, 8'd44, 8'd12, 8'd52, 8'd20, 8'd60, 8'd28,
      8'd35, 8'd3, 8'd43, 8'd11, 8'd51, 8'd19, 8'd59, 8'd27,
      8'd34, 8'd2, 8'd42, 8'd10, 8'd50, 8'd18, 8'd58, 8'd26,
      8'd33, 8'd1, 8'd41, 8'd9,  8'd49, 8'd17, 8'd57, 8'd25};

   localparam tab_entry_type E_TAB [48] = '{
      8'd32, 8'd1,  8'd2,  8'd3,  8'd4,  8'd5,  8'd4,  8'd5,
      8'd6,  8'd7,  8'd8,  8'd9,  8'd8,  8'd9,  8'd10, 8'd11,
      8'd12, 8'd13, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17,
      8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd20, 8'd21,
      8'd22, 8'd23, 8'd24, 8'd25, 8'd24, 8'd25, 8'd26, 8'd27,
      8'd28, 8'd29, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd1};

   localparam tab_entry_type P_TAB [32] = '{
      8'd16, 8'd7,  8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
      8'd1,  8'd15, 8'd23, 8'd26, 8'd5,  8'd18, 8'd31, 8'd10,
      8'd2,  8'd8,  8'd24, 8'd14, 8'd32, 8'd27, 8'd3,  8'd9,
      8'd19, 8'd13, 8'd30, 8'd6,  8'd22, 8'd11, 8'd4,  8'd25};

   localparam tab_entry_type PC1_TAB [56] = '{
      8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
      8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
      8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
      8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
      8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
      8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
      8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
      8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4};

   localparam tab_entry_type PC2_TAB [48] = '{
      8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28,
      8'd15, 8'd6,  8'd21, 8'd10, 8'd23, 8'd19, 8'd12, 8'd4,
      8'd26, 8'd8,  8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
      8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40,
      8'd51, 8'd45, 8'd33, 8'd48, 8'd44, 8'd49, 8'd39, 8'd56,
      8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32};

   // total left rotation of each key half after each round
   localparam tab_entry_type ROT_SUM_TAB [ROUNDS] = '{
      8'd1,  8'd2,  8'd4,  8'd6,  8'd8,  8'd10, 8'd12, 8'd14,
      8'd15, 8'd17, 8'd19, 8'd21, 8'd23, 8'd25, 8'd27, 8'd28};

   localparam logic [3:0] SBOX_TAB [8][64] = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

   // DES bit n of a w-bit word is bit w-n; table entries list output bits MSB first
   function automatic logic [63:0] des_ip(input logic [63:0] v);
      logic [63:0] res;
      for (int k = 0; k < 64; k++) res[63 - k] = v[64 - int'(IP_TAB[k])];
      return res;
   endfunction

   function automatic logic [63:0] des_fp(input logic [63:0] v);
      logic [63:0] res;
      for (int k = 0; k < 64; k++) res[63 - k] = v[64 - int'(FP_TAB[k])];
      return res;
   endfunction

   function automatic logic [47:0] des_e(input logic [31:0] v);
      logic [47:0] res;
      for (int k = 0; k < 48; k++) res[47 - k] = v[32 - int'(E_TAB[k])];
      return res;
   endfunction

   function automatic logic [31:0] des_p(input logic [31:0] v);
      logic [31:0] res;
      for (int k = 0; k < 32; k++) res[31 - k] = v[32 - int'(P_TAB[k])];
      return res;
   endfunction

   function automatic logic [55:0] des_pc1(input logic [63:0] v);
      logic [55:0] res;
      for (int k = 0; k < 56; k++) res[55 - k] = v[64 - int'(PC1_TAB[k])];
      return res;
   endfunction

   function automatic logic [47:0] des_pc2(input logic [55:0] v);
      logic [47:0] res;
      for (int k = 0; k < 48; k++) res[47 - k] = v[56 - int'(PC2_TAB[k])];
      return res;
   endfunction

   function automatic logic [HALF_KEY_BITS-1:0] rotl_half(
      input logic [HALF_KEY_BITS-1:0] v, input int n);
      logic [2*HALF_KEY_BITS-1:0] w;
      w = {v, v} << n;
      return w[2*HALF_KEY_BITS-1:HALF_KEY_BITS];
   endfunction

   function automatic logic [31:0] des_f(input logic [31:0] r, input logic [47:0] rk);
      logic [47:0] x;
      logic [5:0]  six;
      logic [31:0] s;
      x = des_e(r) ^ rk;
      for (int i = 0; i < 8; i++) begin
         six = x[47 - 6*i -: 6];
         s[31 - 4*i -: 4] = SBOX_TAB[i][{six[5], six[0], six[4:1]}];
      end
      return des_p(s);
   endfunction

endpackage

### design/des_block_encrypt.sv
`timescale 1ns / 1ps
// Top level of the DES block encryptor.
//
// Channels: plaintext blocks arrive on req_* (tdata = plain_block), ciphertext
// blocks leave on rsp_* (tdata = cipher_block), in order, one result for each
// transaction taken. The 64-bit key is written on csr_* (always ready); write it
// only while no block is in flight.
//
// The block sits in an input register, all sixteen rounds and the key schedule run
// as one combinational pass, and the ciphertext lands in the result register.
// Throughput: one block per cycle while rsp_tready is high; both registers pass data on.
//
// Reset: drops both stages and clears the key to zero.
// Stall: while rsp_tready is low the result holds; one more block is taken into
// the input register, then req_tready falls until the result is taken.
module des_block_encrypt
   import des_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] plain_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] cipher_block
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data     // [63:0] cipher_key
);

   logic [63:0] key_ff, key_in;
   logic        s1_valid_ff, s1_valid_in;
   logic [63:0] s1_block_ff, s1_block_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_block_ff, rsp_block_in;
   logic        rsp_advance, s1_advance;

   logic [55:0] cd_w;
   logic [63:0] ip_w, cipher_w;
   logic [31:0] l_w [ROUNDS+1];
   logic [31:0] r_w [ROUNDS+1];
   logic [47:0] rk_w [ROUNDS];

   always_comb begin
      rsp_advance  = !rsp_valid_ff || rsp_tready;
      s1_advance   = !s1_valid_ff || rsp_advance;
      key_in       = csr_valid ? csr_data : key_ff;
      s1_valid_in  = s1_advance ? req_tvalid : s1_valid_ff;
      s1_block_in  = s1_advance ? req_tdata : s1_block_ff;
      rsp_valid_in = rsp_advance ? s1_valid_ff : rsp_valid_ff;
      rsp_block_in = rsp_advance ? cipher_w : rsp_block_ff;
   end

   assign cd_w   = des_pc1(key_ff);
   assign ip_w   = des_ip(s1_block_ff);
   assign l_w[0] = ip_w[63:32];
   assign r_w[0] = ip_w[31:0];

   for (genvar g = 0; g < ROUNDS; g++) begin : g_round
      assign rk_w[g] = des_pc2({rotl_half(cd_w[55:28], int'(ROT_SUM_TAB[g])),
                                rotl_half(cd_w[27:0], int'(ROT_SUM_TAB[g]))});
      assign l_w[g+1] = r_w[g];
      assign r_w[g+1] = l_w[g] ^ des_f(r_w[g], rk_w[g]);
   end

   assign cipher_w = des_fp({r_w[ROUNDS], l_w[ROUNDS]});

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_block_ff  <= s1_block_in;
      rsp_block_ff <= rsp_block_in;
   end

   assign req_tready = s1_advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_block_ff;
   assign csr_ready  = 1'b1;

endmodule

### design/des_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the DES block encryptor, with its bind.
module des_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready ##1 !rsp_tvalid |=> rsp_tvalid)
      else $error("accepted block did not reach the result register");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without a stalled result");

endmodule

bind des_block_encrypt des_chk u_des_chk (.*);

### sim/tb_des_block_encrypt.sv
`timescale 1ns / 1ps
// Self-checking testbench for the DES block encryptor: known-answer rows, random blocks and keys.
module tb_des_block_encrypt;

   localparam int  CLOCK_HALF    = 4;
   localparam int  RESET_CYCLES  = 10;
   localparam int  SETTLE_CYCLES = 4;
   localparam int  PHASES        = 8;
   localparam int  PHASE_ITEMS   = 150;
   localparam int  BURST_ITEMS   = 24;
   localparam int  HOLD_CYCLES   = 80;
   localparam int  CYCLE_LIMIT   = 600000;

   localparam int IP_MAP [64] = '{
      58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

   localparam int FP_MAP [64] = '{
      40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

   localparam int EXPAND_MAP [48] = '{
      32,1,2,3,4,5,       4,5,6,7,8,9,       8,9,10,11,12,13,   12,13,14,15,16,17,
      16,17,18,19,20,21,  20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

   localparam int PERM_MAP [32] = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

   localparam int KEY_SELECT_MAP [56] = '{
      57,49,41,33,25,17,9,  1,58,50,42,34,26,18,
      10,2,59,51,43,35,27,  19,11,3,60,52,44,36,
      63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
      14,6,61,53,45,37,29,  21,13,5,28,20,12,4};

   localparam int SUBKEY_MAP [48] = '{
      14,17,11,24,1,5,  3,28,15,6,21,10,  23,19,12,4,26,8,  16,7,27,20,13,2,
      41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

   localparam int SHIFT_MAP [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

   localparam int SBOX_MAP [512] = '{
      14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,    0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,    15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13,
      15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,    3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,    13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9,
      10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,    13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,    1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12,
      7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,    13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,    3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14,
      2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,    14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,    11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3,
      12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,    10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,    4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13,
      4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,    13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,    6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12,
      13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,    1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,    2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11};

   typedef struct packed {
      logic [63:0] key;
      logic [63:0] plain;
      logic [63:0] cipher;
      logic        typed;
   } kat_row_type;

   typedef struct {
      logic [63:0] plain;
      logic [63:0] cipher;
   } block_pair_type;

   localparam int KAT_ROWS = 20;

   kat_row_type kat_table [KAT_ROWS] = '{
      '{64'h0000000000000000, 64'h0000000000000000, 64'h8CA64DE9C1B123A7, 1'b1},
      '{64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF, 64'h0,                1'b0},
      '{64'h0000000000000000, 64'h8000000000000000, 64'h0,                1'b0},
      '{64'h0000000000000000, 64'h0000000000000001, 64'h0,                1'b0},
      '{64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 64'h7359B2163E4EDC58, 1'b1},
      '{64'hFFFFFFFFFFFFFFFF, 64'h0000000000000000, 64'h0,                1'b0},
      '{64'h133457799BBCDFF1, 64'h0123456789ABCDEF, 64'h85E813540F0AB405, 1'b1},
      '{64'h133457799BBCDFF1, 64'hFEDCBA9876543210, 64'h0,                1'b0},
      '{64'h0123456789ABCDEF, 64'h4E6F772069732074, 64'h3FA40E8A984D4815, 1'b1},
      '{64'h0E329232EA6D0D73, 64'h8787878787878787, 64'h0000000000000000, 1'b1},
      '{64'h0101010101010101, 64'h0000000000000000, 64'h8CA64DE9C1B123A7, 1'b1},
      '{64'h0101010101010101, 64'hAAAAAAAAAAAAAAAA, 64'h0,                1'b0},
      '{64'hFEFEFEFEFEFEFEFE, 64'hFFFFFFFFFFFFFFFF, 64'h7359B2163E4EDC58, 1'b1},
      '{64'hFEFEFEFEFEFEFEFE, 64'h5555555555555555, 64'h0,                1'b0},
      '{64'h1F1F1F1F0E0E0E0E, 64'h0123456789ABCDEF, 64'h0,                1'b0},
      '{64'hE0E0E0E0F1F1F1F1, 64'h0123456789ABCDEF, 64'h0,                1'b0},
      '{64'h0000000000000001, 64'h0000000000000000, 64'h8CA64DE9C1B123A7, 1'b1},
      '{64'h8000000000000000, 64'h0000000000000000, 64'h0,                1'b0},
      '{64'h8000000000000000, 64'hFFFFFFFFFFFFFFFF, 64'h0,                1'b0},
      '{64'h0000000000000000, 64'h0000000000000000, 64'h8CA64DE9C1B123A7, 1'b1}};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [63:0] csr_data   = '0;

   block_pair_type pending_cipher [$];
   logic [63:0] active_key    = '0;
   int          mismatches    = 0;
   int          blocks_sent   = 0;
   int          blocks_checked = 0;
   int          key_loads     = 0;
   int          cycle_count   = 0;
   int          hold_request  = 0;
   bit          steady        = 1'b0;

   des_block_encrypt DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   function automatic logic [63:0] des_encrypt_block(input logic [63:0] key,
                                                      input logic [63:0] plain);
      logic [55:0] cd;
      logic [55:0] wide;
      logic [27:0] c;
      logic [27:0] d;
      logic [47:0] subkey;
      logic [47:0] mixed;
      logic [63:0] blk;
      logic [63:0] swapped;
      logic [63:0] result;
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] sbox_out;
      logic [31:0] f_out;
      logic [31:0] t;
      logic [5:0]  six;
      int          row;
      int          col;
      for (int k = 0; k < 56; k++) cd[55 - k] = key[64 - KEY_SELECT_MAP[k]];
      c = cd[55:28];
      d = cd[27:0];
      for (int k = 0; k < 64; k++) blk[63 - k] = plain[64 - IP_MAP[k]];
      l = blk[63:32];
      r = blk[31:0];
      for (int rnd = 0; rnd < 16; rnd++) begin
         wide = {c, c} >> (28 - SHIFT_MAP[rnd]);
         c = wide[27:0];
         wide = {d, d} >> (28 - SHIFT_MAP[rnd]);
         d = wide[27:0];
         cd = {c, d};
         for (int k = 0; k < 48; k++) subkey[47 - k] = cd[56 - SUBKEY_MAP[k]];
         for (int k = 0; k < 48; k++) mixed[47 - k] = r[32 - EXPAND_MAP[k]];
         mixed = mixed ^ subkey;
         for (int i = 0; i < 8; i++) begin
            six = mixed[47 - 6*i -: 6];
            row = int'({six[5], six[0]});
            col = int'(six[4:1]);
            sbox_out[31 - 4*i -: 4] = 4'(SBOX_MAP[i*64 + row*16 + col]);
         end
         for (int k = 0; k < 32; k++) f_out[31 - k] = sbox_out[32 - PERM_MAP[k]];
         t = l ^ f_out;
         l = r;
         r = t;
      end
      swapped = {r, l};
      for (int k = 0; k < 64; k++) result[63 - k] = swapped[64 - FP_MAP[k]];
      return result;
   endfunction

   function automatic logic [63:0] pick_word();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      case (sel)
         0:       return '0;
         1:       return '1;
         2:       return 64'd1 << $urandom_range(0, 63);
         3:       return ~(64'd1 << $urandom_range(0, 63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic int sender_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic offer_block(input logic [63:0] plain, input logic [63:0] cipher);
      block_pair_type pair;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= plain;
      do @(posedge clock); while (!req_tready);
      pair.plain  = plain;
      pair.cipher = cipher;
      pending_cipher.push_back(pair);
      blocks_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_cipher.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_key(input logic [63:0] key);
      wait_for_drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= key;
      do @(posedge clock); while (!csr_ready);
      active_key = key;
      key_loads++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // output side: random ready with short and long stalls, steady ready, or a commanded hold
   initial begin
      int hold_left;
      int run;
      bit level;
      hold_left = 0;
      run       = 0;
      level     = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            if (run == 0) begin
               level = ~level;
               if (level) run = $urandom_range(1, 12);
               else if ($urandom_range(0, 99) < 85) run = $urandom_range(1, 3);
               else run = $urandom_range(12, 40);
            end
            rsp_tready <= level;
            run--;
         end
      end
   end

   always @(posedge clock) begin
      block_pair_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cipher.size() == 0) begin
            report($sformatf("unexpected ciphertext %h", rsp_tdata));
         end else begin
            want = pending_cipher.pop_front();
            blocks_checked++;
            if (rsp_tdata !== want.cipher)
               report($sformatf("plaintext %h: cipher_block %h, want %h",
                                want.plain, rsp_tdata, want.cipher));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d ciphertexts outstanding",
                  cycle_count, pending_cipher.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      logic [63:0] plain;
      logic [63:0] cipher;
      int          gap;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // known-answer and corner rows; key reloads happen only with the pipe empty
      for (int i = 0; i < KAT_ROWS; i++) begin
         if (kat_table[i].key != active_key) load_key(kat_table[i].key);
         plain  = kat_table[i].plain;
         cipher = kat_table[i].typed ? kat_table[i].cipher
                                     : des_encrypt_block(active_key, plain);
         gap = sender_gap();
         if (gap > 0) idle_sender(gap);
         offer_block(plain, cipher);
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            1:       load_key('0);
            3:       load_key('1);
            default: load_key(pick_word());
         endcase
         steady = (p == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // stall the output long enough for the input to back up
            if (p == 2 && n == 0) hold_request = HOLD_CYCLES;
            // pause the input until every ciphertext is back
            if (p == 3 && n == PHASE_ITEMS / 2) wait_for_drain();
            gap = (steady || (p == 2 && n < BURST_ITEMS)) ? 0 : sender_gap();
            if (gap > 0) idle_sender(gap);
            plain = pick_word();
            offer_block(plain, des_encrypt_block(active_key, plain));
         end
      end

      wait_for_drain();
      $display("Encrypted %0d blocks under %0d key loads; %0d ciphertexts compared.",
               blocks_sent, key_loads, blocks_checked);
      $display("Included known-answer vectors, parity and weak keys, full-rate traffic,");
      $display("a long output stall with input backpressure, and an input pause to empty.");
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

### files.f
design/des_pkg.sv
design/des_block_encrypt.sv
design/des_chk.sv
sim/tb_des_block_encrypt.sv
